>>> hw/rtl/dmcm_pkg.sv
// Shared constants, types and command/status structs for the depth mean colour mapper.
`default_nettype none

package dmcm_pkg;

  // Ray and sample geometry
  localparam int MAX_DEPTH = 256;
  localparam int NUM_CH    = 3;
  localparam int CH_W      = $clog2(NUM_CH);
  localparam int SAMPLE_W  = 16;
  localparam int OFF_W     = 16;
  localparam int GAIN_W    = 24;
  localparam int GAIN_FRAC = 16;
  localparam int BYTE_W    = 8;

  // Fraction bits of (sample - offset) * gain: Q8.8 times Q8.16
  localparam int FRAC_W = 8 + GAIN_FRAC;

  // Accumulator and arithmetic widths
  localparam int CNT_W  = $clog2(MAX_DEPTH + 1);
  localparam int SUM_W  = SAMPLE_W + $clog2(MAX_DEPTH) + 1;
  localparam int PROD_W = OFF_W + CNT_W + 1;
  localparam int DIFF_W = ((SUM_W > PROD_W) ? SUM_W : PROD_W) + 1;
  localparam int T_W    = DIFF_W + GAIN_W;
  localparam int POS_W  = CNT_W + FRAC_W;
  localparam int NUM_W  = POS_W + BYTE_W + 1;
  localparam int REM_W  = NUM_W - FRAC_W;
  localparam int DVS_W  = CNT_W + BYTE_W - 1;
  localparam int STEP_W = $clog2(BYTE_W);

  // Configuration port
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 24;
  localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << GAIN_FRAC;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RED_OFFSET   = 4'd0,
    REG_RED_GAIN     = 4'd1,
    REG_GREEN_OFFSET = 4'd2,
    REG_GREEN_GAIN   = 4'd3,
    REG_BLUE_OFFSET  = 4'd4,
    REG_BLUE_GAIN    = 4'd5,
    REG_BACKGROUND   = 4'd6,
    REG_CH_ENABLE    = 4'd7
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_ACCUM,
    ST_CHECK,
    ST_MUL_OFF,
    ST_SUB,
    ST_MUL_GAIN,
    ST_SCALE,
    ST_DIVIDE,
    ST_STORE,
    ST_PUBLISH
  } state_t;

  typedef struct packed {
    logic [NUM_CH-1:0][OFF_W-1:0]  offset;
    logic [NUM_CH-1:0][GAIN_W-1:0] gain;
    logic [NUM_CH*BYTE_W-1:0]      background;
    logic [NUM_CH-1:0]             enable;
  } cfg_t;

  typedef struct packed {
    logic [NUM_CH-1:0][SAMPLE_W-1:0] value;
    logic                            tissue;
  } sample_t;

  typedef struct packed {
    logic            accumulate;
    logic            mul_off;
    logic            sub;
    logic            mul_gain;
    logic            scale;
    logic            div_step;
    logic            store;
    logic            publish;
    logic [CH_W-1:0] ch;
  } cmd_t;

  typedef struct packed {
    logic count_zero;
    logic out_busy;
  } stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/dmcm_ctrl.sv
// Sequencer for ray accumulation and the per-channel end-of-ray arithmetic.
`default_nettype none

module dmcm_ctrl
  import dmcm_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  input  wire logic  in_last,
  input  wire stat_t stat,
  output cmd_t       cmd,
  output logic       ready
);

  state_t            state, state_next;
  logic [CH_W-1:0]   ch, ch_next;
  logic [STEP_W-1:0] step, step_next;

  // Hold state, channel and divider step
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_ACCUM;
      ch    <= '0;
      step  <= '0;
    end else begin
      state <= state_next;
      ch    <= ch_next;
      step  <= step_next;
    end
  end

  // Advance through the per-channel sequence and drive datapath commands
  always_comb begin
    state_next = state;
    ch_next    = ch;
    step_next  = step;
    cmd        = '0;
    cmd.ch     = ch;
    ready      = 1'b0;
    unique case (state)
      ST_ACCUM: begin
        ready          = 1'b1;
        cmd.accumulate = in_valid;
        if (in_valid && in_last) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        ch_next = '0;
        if (stat.count_zero) begin
          state_next = ST_PUBLISH;
        end else begin
          state_next = ST_MUL_OFF;
        end
      end
      ST_MUL_OFF: begin
        cmd.mul_off = 1'b1;
        state_next  = ST_SUB;
      end
      ST_SUB: begin
        cmd.sub    = 1'b1;
        state_next = ST_MUL_GAIN;
      end
      ST_MUL_GAIN: begin
        cmd.mul_gain = 1'b1;
        state_next   = ST_SCALE;
      end
      ST_SCALE: begin
        cmd.scale  = 1'b1;
        step_next  = '0;
        state_next = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        step_next    = step + 1'b1;
        if (step == STEP_W'(BYTE_W - 1)) begin
          state_next = ST_STORE;
        end
      end
      ST_STORE: begin
        cmd.store = 1'b1;
        if (ch == CH_W'(NUM_CH - 1)) begin
          state_next = ST_PUBLISH;
        end else begin
          ch_next    = ch + 1'b1;
          state_next = ST_MUL_OFF;
        end
      end
      ST_PUBLISH: begin
        if (!stat.out_busy) begin
          cmd.publish = 1'b1;
          state_next  = ST_ACCUM;
        end
      end
      default: begin
        state_next = ST_ACCUM;
      end
    endcase
  end

  // The end of a ray always leaves the accumulate state
  a_last_ends_ray: assert property (@(posedge clk) disable iff (rst)
    (cmd.accumulate && in_last) |=> (state == ST_CHECK))
    else $error("last sample of a ray did not start the pixel computation");

endmodule

`default_nettype wire

>>> hw/rtl/dmcm_datapath.sv
// Accumulators, shared multiply/scale stages and restoring divider for one pixel.
`default_nettype none

module dmcm_datapath
  import dmcm_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire cmd_t                     cmd,
  input  wire sample_t                  sample,
  input  wire cfg_t                     cfg,
  output stat_t                         stat_partial,
  output logic [NUM_CH-1:0][BYTE_W-1:0] pixel,
  output logic                          pixel_void
);

  logic signed [SUM_W-1:0]         sum [NUM_CH];
  logic [CNT_W-1:0]                count;
  logic signed [PROD_W-1:0]        prod;
  logic signed [DIFF_W-1:0]        diff;
  logic signed [T_W-1:0]           t;
  logic                            clip_lo;
  logic                            clip_hi;
  logic [REM_W-1:0]                rem;
  logic [DVS_W-1:0]                dvs;
  logic [BYTE_W-1:0]               quo;
  logic [NUM_CH-1:0][BYTE_W-1:0]   colour;

  logic signed [SUM_W-1:0]         sel_sum;
  logic [OFF_W-1:0]                sel_off;
  logic [GAIN_W-1:0]               sel_gain;
  logic                            sel_en;
  logic signed [T_W-1:0]           one;
  logic [POS_W-1:0]                t_pos;
  logic [NUM_W-1:0]                num;
  logic                            ge;
  logic [BYTE_W-1:0]               byte_val;

  // Pick the operands of the channel being worked on
  always_comb begin
    sel_sum  = sum[0];
    sel_off  = cfg.offset[0];
    sel_gain = cfg.gain[0];
    sel_en   = cfg.enable[0];
    for (int k = 1; k < NUM_CH; k++) begin
      if (cmd.ch == CH_W'(k)) begin
        sel_sum  = sum[k];
        sel_off  = cfg.offset[k];
        sel_gain = cfg.gain[k];
        sel_en   = cfg.enable[k];
      end
    end
  end

  // Accumulate tissue samples, drop those past the depth limit, clear on publish
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      for (int k = 0; k < NUM_CH; k++) begin
        sum[k] <= '0;
      end
    end else if (cmd.publish) begin
      count <= '0;
      for (int k = 0; k < NUM_CH; k++) begin
        sum[k] <= '0;
      end
    end else if (cmd.accumulate && sample.tissue && (count < CNT_W'(MAX_DEPTH))) begin
      count <= count + 1'b1;
      for (int k = 0; k < NUM_CH; k++) begin
        sum[k] <= sum[k] + SUM_W'($signed(sample.value[k]));
      end
    end
  end

  // Scale terms: one = count in the fraction format, numerator rounds half up
  assign one   = $signed({{(T_W - POS_W){1'b0}}, count, {FRAC_W{1'b0}}});
  assign t_pos = t[POS_W-1:0];
  assign num   = (NUM_W'(t_pos) << BYTE_W) - NUM_W'(t_pos)
               + (NUM_W'(count) << (FRAC_W - 1));
  assign ge    = (REM_W'(dvs) <= rem);

  // Multiply, subtract, multiply, scale, then divide by count one quotient bit a step, and store
  always_ff @(posedge clk) begin
    if (cmd.mul_off) begin
      prod <= PROD_W'($signed(sel_off) * $signed({1'b0, count}));
    end
    if (cmd.sub) begin
      diff <= DIFF_W'(sel_sum) - DIFF_W'(prod);
    end
    if (cmd.mul_gain) begin
      t <= T_W'(diff * $signed(sel_gain));
    end
    if (cmd.scale) begin
      clip_lo <= (t <= 0);
      clip_hi <= (t >= one);
      rem     <= num[NUM_W-1:FRAC_W];
      dvs     <= DVS_W'(count) << (BYTE_W - 1);
      quo     <= '0;
    end
    if (cmd.div_step) begin
      if (ge) begin
        rem <= rem - REM_W'(dvs);
      end
      quo <= {quo[BYTE_W-2:0], ge};
      dvs <= dvs >> 1;
    end
    if (cmd.store) begin
      for (int k = 0; k < NUM_CH; k++) begin
        if (cmd.ch == CH_W'(k)) begin
          colour[k] <= byte_val;
        end
      end
    end
  end

  // Clip to [0,1], zero a disabled channel
  always_comb begin
    if (!sel_en || clip_lo) begin
      byte_val = '0;
    end else if (clip_hi) begin
      byte_val = '1;
    end else begin
      byte_val = quo;
    end
  end

  // Empty ray shows the background, red held in its top byte
  always_comb begin
    pixel_void = (count == '0);
    for (int k = 0; k < NUM_CH; k++) begin
      if (pixel_void) begin
        pixel[k] = cfg.background[(NUM_CH - 1 - k) * BYTE_W +: BYTE_W];
      end else begin
        pixel[k] = colour[k];
      end
    end
  end

  assign stat_partial.count_zero = pixel_void;
  assign stat_partial.out_busy   = 1'b0;

  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_DEPTH))
    else $error("tissue count passed the depth limit");

  a_clear_after_pixel: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |=> (count == '0) && (sum[0] == '0))
    else $error("accumulators not cleared after a pixel");

endmodule

`default_nettype wire

>>> hw/rtl/depth_mean_colour_mapper.sv
// Top level: configuration registers, stream ports and the output pixel register.
`default_nettype none

// Average intensity projection along depth rays. Samples stream in on s_axis,
// one per cycle while a ray is being accumulated; tissue samples add into
// per-channel sums (at most MAX_DEPTH per ray). The sample flagged by tlast
// closes the ray and starts the pixel computation, during which s_axis_tready
// is low: for a ray with tissue, a check state, then the three channels in
// turn through one shared offset multiply, subtract, gain multiply, scaling
// step, 8-step restoring divider and store, then a hand-off state; for an
// empty ray, only the check and hand-off states. The pixel then sits in the
// output register while the next ray streams in. Configuration writes are
// taken at any time but are meant for idle periods.

module depth_mean_colour_mapper
  import dmcm_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  // Sample stream
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [47:0]           s_axis_tdata,  // sample_red, sample_green, sample_blue
  input  wire logic                  s_axis_tuser,  // is_tissue
  input  wire logic                  s_axis_tlast,  // last_of_ray
  // Pixel stream
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [23:0]                m_axis_tdata,  // red, green, blue
  output logic                       m_axis_tuser,  // was_void
  // Register writes
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t                          cfg;
  cmd_t                          cmd;
  stat_t                         stat;
  stat_t                         dp_stat;
  sample_t                       sample;
  logic [NUM_CH-1:0][BYTE_W-1:0] pixel;
  logic                          pixel_void;

  // Write configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.offset     <= '0;
      cfg.gain       <= {NUM_CH{GAIN_ONE}};
      cfg.background <= '0;
      cfg.enable     <= '1;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_RED_OFFSET:   cfg.offset[0]  <= cfg_data[OFF_W-1:0];
        REG_RED_GAIN:     cfg.gain[0]    <= cfg_data[GAIN_W-1:0];
        REG_GREEN_OFFSET: cfg.offset[1]  <= cfg_data[OFF_W-1:0];
        REG_GREEN_GAIN:   cfg.gain[1]    <= cfg_data[GAIN_W-1:0];
        REG_BLUE_OFFSET:  cfg.offset[2]  <= cfg_data[OFF_W-1:0];
        REG_BLUE_GAIN:    cfg.gain[2]    <= cfg_data[GAIN_W-1:0];
        REG_BACKGROUND:   cfg.background <= cfg_data[NUM_CH*BYTE_W-1:0];
        REG_CH_ENABLE:    cfg.enable     <= cfg_data[NUM_CH-1:0];
        default: begin
        end
      endcase
    end
  end

  // Unpack the sample request
  assign sample.value  = s_axis_tdata;
  assign sample.tissue = s_axis_tuser;

  assign stat.count_zero = dp_stat.count_zero;
  assign stat.out_busy   = m_axis_tvalid && !m_axis_tready;

  dmcm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_last  (s_axis_tlast),
    .stat     (stat),
    .cmd      (cmd),
    .ready    (s_axis_tready)
  );

  dmcm_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sample       (sample),
    .cfg          (cfg),
    .stat_partial (dp_stat),
    .pixel        (pixel),
    .pixel_void   (pixel_void)
  );

  // Hold the finished pixel until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (cmd.publish) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      m_axis_tdata <= pixel;
      m_axis_tuser <= pixel_void;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |-> !(m_axis_tvalid && !m_axis_tready))
    else $error("pixel published over one not yet taken");

endmodule

`default_nettype wire
